>>> hdl/pip_pkg.sv
`default_nettype none

package pip_pkg;

    // Defaults for the top-level parameters
    localparam int MaxVertices = 16;
    localparam int CoordBits   = 32;

    // Fixed port widths
    localparam int PortCoordBits = 32;
    localparam int SlotBits      = 4;
    localparam int VcountBits    = 5;
    localparam int CountOutBits  = 5;

    // Request opcode
    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    // One request as it moves down the cell row
    typedef struct packed {
        logic                     valid;
        t_func                    func;
        logic [SlotBits-1:0]      slot;
        logic [PortCoordBits-1:0] x;
        logic [PortCoordBits-1:0] y;
    } t_req;

endpackage

`default_nettype wire

>>> hdl/pip_cell.sv
`default_nettype none

// One edge cell: holds the start and end vertex of its edge plus its own
// copy of vertex 0 (the wrap target). Stage 1 forms the two cross products,
// stage 2 compares them and bumps the running crossing count.
module pip_cell
    import pip_pkg::*;
#(
    parameter int COORD_BITS   = CoordBits,
    parameter int CELL_IDX     = 0,
    parameter int CNT_W        = $clog2(MaxVertices + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,
    input  wire logic [CNT_W-1:0] i_n_eff,
    input  wire t_req             i_req,
    input  wire logic [CNT_W-1:0] i_count,
    output t_req                  o_req,
    output logic      [CNT_W-1:0] o_count
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    // Vertex storage, written by load requests as they pass this cell
    logic signed [COORD_BITS-1:0] r_sx, r_sy;
    logic signed [COORD_BITS-1:0] r_ex, r_ey;
    logic signed [COORD_BITS-1:0] r_zx, r_zy;

    // Stage registers
    t_req                r_mid_req;
    logic [CNT_W-1:0]    r_mid_count;
    logic signed [PW-1:0] r_lhs, r_rhs;
    logic                r_cand;
    logic                r_dy_pos;
    t_req                r_out_req;
    logic [CNT_W-1:0]    r_out_count;

    logic signed [COORD_BITS-1:0] w_px, w_py, w_ex, w_ey;
    logic signed [DW-1:0]         w_a, w_b, w_c, w_dy;
    logic signed [PW-1:0]         w_lhs, w_rhs;
    logic                         w_wrap, w_active, w_straddle, w_is_load;
    logic                         w_hit;
    logic [CNT_W-1:0]             n_count;

    // Edge end point: vertex 0 on the closing edge
    assign w_wrap   = (i_n_eff == CNT_W'(CELL_IDX + 1));
    assign w_active = (CNT_W'(CELL_IDX) < i_n_eff);
    assign w_ex     = w_wrap ? r_zx : r_ex;
    assign w_ey     = w_wrap ? r_zy : r_ey;

    assign w_px = i_req.x[COORD_BITS-1:0];
    assign w_py = i_req.y[COORD_BITS-1:0];

    // Differences one bit wider than the coordinates, then exact products
    assign w_a  = {w_px[COORD_BITS-1], w_px} - {r_sx[COORD_BITS-1], r_sx};
    assign w_b  = {w_py[COORD_BITS-1], w_py} - {r_sy[COORD_BITS-1], r_sy};
    assign w_c  = {w_ex[COORD_BITS-1], w_ex} - {r_sx[COORD_BITS-1], r_sx};
    assign w_dy = {w_ey[COORD_BITS-1], w_ey} - {r_sy[COORD_BITS-1], r_sy};

    assign w_lhs = w_a * w_dy;
    assign w_rhs = w_b * w_c;

    assign w_straddle = (r_sy > w_py) != (w_ey > w_py);
    assign w_is_load  = i_req.valid && (i_req.func == FUNC_LOAD);

    // Vertex writes by a passing load
    always_ff @(posedge i_clk) begin
        if (i_advance && w_is_load) begin
            if (int'(i_req.slot) == CELL_IDX) begin
                r_sx <= w_px;
                r_sy <= w_py;
            end
            if (int'(i_req.slot) == CELL_IDX + 1) begin
                r_ex <= w_px;
                r_ey <= w_py;
            end
            if (i_req.slot == '0) begin
                r_zx <= w_px;
                r_zy <= w_py;
            end
        end
    end

    // Stage 1: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_req.valid <= 1'b0;
        end else if (i_advance) begin
            r_mid_req   <= i_req;
            r_mid_count <= i_count;
            r_lhs       <= w_lhs;
            r_rhs       <= w_rhs;
            r_cand      <= w_active && w_straddle && (i_req.func == FUNC_QUERY);
            r_dy_pos    <= !w_dy[DW-1];
        end
    end

    // Stage 2: crossing test, sign of dy picks the compare direction
    assign w_hit   = r_cand && (r_dy_pos ? (r_lhs < r_rhs) : (r_rhs < r_lhs));
    assign n_count = r_mid_count + CNT_W'(w_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_req.valid <= 1'b0;
        end else if (i_advance) begin
            r_out_req   <= r_mid_req;
            r_out_count <= n_count;
        end
    end

    assign o_req   = r_out_req;
    assign o_count = r_out_count;

endmodule

`default_nettype wire

>>> hdl/point_in_polygon.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        input      i_in_valid/o_in_stall i_func, i_vertex_index, i_x_coord, i_y_coord
// out       output     o_out_valid/i_out_stall o_inside_res, o_crossing_count
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_data (vertex count)
//
// Requests flow down a row of MAX_VERTICES edge cells, two register stages
// per cell (products, then compare); one request enters per cycle while
// the row is not stalled.
// Loads travel the same row and update each cell's vertex copies in order.
// Synchronous active-low reset clears the stage valids and the vertex count;
// vertex storage is not cleared. A held output stalls the whole row.
module point_in_polygon
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MaxVertices,
    parameter int COORD_BITS   = CoordBits
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // request channel
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic                     i_func,
    input  wire logic [SlotBits-1:0]      i_vertex_index,
    input  wire logic [PortCoordBits-1:0] i_x_coord,
    input  wire logic [PortCoordBits-1:0] i_y_coord,
    // result channel
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic                          o_inside_res,
    output logic [CountOutBits-1:0]       o_crossing_count,
    // configuration
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [VcountBits-1:0]    i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    logic [VcountBits-1:0] r_vertex_count;
    logic [CNT_W-1:0]      w_n_eff;
    logic                  w_advance;
    t_req                  w_req   [0:MAX_VERTICES];
    logic [CNT_W-1:0]      w_count [0:MAX_VERTICES];

    // Vertex count register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    // Clamp to the table depth
    assign w_n_eff = (int'(r_vertex_count) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                           : CNT_W'(r_vertex_count);

    // Whole row moves unless a result is held
    assign w_advance  = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_advance;

    // Request entering the first cell
    assign w_req[0]   = {i_in_valid && w_advance, t_func'(i_func), i_vertex_index,
                         i_x_coord, i_y_coord};
    assign w_count[0] = '0;

    // Edge cell row
    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        pip_cell #(
            .COORD_BITS   (COORD_BITS),
            .CELL_IDX     (k),
            .CNT_W        (CNT_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_n_eff   (w_n_eff),
            .i_req     (w_req[k]),
            .i_count   (w_count[k]),
            .o_req     (w_req[k+1]),
            .o_count   (w_count[k+1])
        );
    end

    // Result: only queries leave the row as results
    assign o_out_valid      = w_req[MAX_VERTICES].valid &&
                              (w_req[MAX_VERTICES].func == FUNC_QUERY);
    assign o_inside_res     = w_count[MAX_VERTICES][0];
    assign o_crossing_count = CountOutBits'(w_count[MAX_VERTICES]);

endmodule

`default_nettype wire

>>> tb/sv/point_in_polygon_tb.sv
module point_in_polygon_tb;
    import pip_pkg::*;

    localparam int NumSlots  = MaxVertices;
    localparam int RowDepth  = 2 * MaxVertices;
    localparam int DrainWait = RowDepth + 8;
    localparam int LongHold  = 160;
    localparam int IdleLimit = 4000;
    localparam int TotalReqs = 1400;
    localparam int HoldAfter = 600;

    typedef struct {
        t_func                    func;
        logic [SlotBits-1:0]      slot;
        logic [PortCoordBits-1:0] x;
        logic [PortCoordBits-1:0] y;
    } t_fence_req;

    typedef struct {
        logic                    in_poly;
        logic [CountOutBits-1:0] count;
    } t_fence_res;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind             kind;
        t_fence_req            req;
        logic                  typed;
        t_fence_res            res;
        logic [VcountBits-1:0] vcount;
    } t_dir_row;

    logic                     i_clk;
    logic                     i_rst_n        = 1'b0;
    logic                     i_in_valid     = 1'b0;
    logic                     o_in_stall;
    logic                     i_func         = 1'b0;
    logic [SlotBits-1:0]      i_vertex_index = '0;
    logic [PortCoordBits-1:0] i_x_coord      = '0;
    logic [PortCoordBits-1:0] i_y_coord      = '0;
    logic                     o_out_valid;
    logic                     i_out_stall    = 1'b0;
    logic                     o_inside_res;
    logic [CountOutBits-1:0]  o_crossing_count;
    logic                     i_cfg_valid    = 1'b0;
    logic                     o_cfg_ready;
    logic [VcountBits-1:0]    i_cfg_data     = '0;

    // fence predictor state
    logic signed [PortCoordBits-1:0] fence_x [NumSlots];
    logic signed [PortCoordBits-1:0] fence_y [NumSlots];
    logic [VcountBits-1:0]           fence_vcount = '0;
    t_fence_res                      fence_exp_q [$];

    logic [NumSlots-1:0] poly_built = '0;   // slots loaded in the current phase
    int                  err_count  = 0;
    int                  reqs_sent  = 0;
    int                  burst_left = 0;
    int                  idle_run   = 0;
    bit                  hold_req   = 1'b0;

    point_in_polygon dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Crossing count of a rightward ray from (px, py), exact wide compare
    function automatic t_fence_res fence_crossings(logic signed [PortCoordBits-1:0] px,
                                                   logic signed [PortCoordBits-1:0] py);
        t_fence_res r;
        int n, i, j, hits;
        logic signed [71:0] xi, yi, xj, yj, qx, qy, dy, lhs, rhs;
        logic hit;
        n = (fence_vcount > NumSlots) ? NumSlots : int'(fence_vcount);
        hits = 0;
        qx = px;
        qy = py;
        for (i = 0; i < n; i++) begin
            j = (i + 1 == n) ? 0 : i + 1;
            if ((fence_y[i] > py) != (fence_y[j] > py)) begin
                xi = fence_x[i];
                yi = fence_y[i];
                xj = fence_x[j];
                yj = fence_y[j];
                dy = yj - yi;
                lhs = (qx - xi) * dy;
                rhs = (qy - yi) * (xj - xi);
                hit = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
                if (hit) hits++;
            end
        end
        r.in_poly = hits[0];
        r.count   = hits[CountOutBits-1:0];
        return r;
    endfunction

    function automatic logic [PortCoordBits-1:0] rand_coord(int scale);
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        case (scale)
            0: return $urandom_range(0, 128) - 64;
            1: return $urandom_range(0, 1 << 21) - (1 << 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_dir_row req_row(t_func f, int slot, logic [PortCoordBits-1:0] x,
                                         logic [PortCoordBits-1:0] y, logic typed = 1'b0,
                                         logic ins = 1'b0, int cnt = 0);
        t_dir_row r;
        r.kind        = ROW_REQ;
        r.req.func    = f;
        r.req.slot    = slot[SlotBits-1:0];
        r.req.x       = x;
        r.req.y       = y;
        r.typed       = typed;
        r.res.in_poly = ins;
        r.res.count   = cnt[CountOutBits-1:0];
        r.vcount      = '0;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(int vc);
        t_dir_row r;
        r = req_row(FUNC_LOAD, 0, '0, '0);
        r.kind   = ROW_CFG;
        r.vcount = vc[VcountBits-1:0];
        return r;
    endfunction

    // Sender bursts: random gaps between bursts, none while the long hold runs
    task automatic pace();
        if (!hold_req) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(1, 12);
            end
            burst_left--;
        end
    endtask

    // Offer one request, hold it until taken, then update the predictor
    task automatic send_req(input t_fence_req rq, input logic typed, input t_fence_res want);
        t_fence_res res;
        i_in_valid     <= 1'b1;
        i_func         <= rq.func;
        i_vertex_index <= rq.slot;
        i_x_coord      <= rq.x;
        i_y_coord      <= rq.y;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        reqs_sent++;
        if (rq.func == FUNC_LOAD) begin
            fence_x[rq.slot]   = rq.x;
            fence_y[rq.slot]   = rq.y;
            poly_built[rq.slot] = 1'b1;
        end else begin
            res = fence_crossings(rq.x, rq.y);
            fence_exp_q.push_back(typed ? want : res);
        end
    endtask

    // Vertex count write, only once the row has drained
    task automatic write_vcount(input logic [VcountBits-1:0] vc);
        i_in_valid <= 1'b0;
        while (fence_exp_q.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= vc;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        fence_vcount = vc;
        i_cfg_valid <= 1'b0;
    endtask

    // Result checker
    always @(posedge i_clk) begin : chk_out
        t_fence_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (fence_exp_q.size() == 0) begin
                $display("%0t: unexpected result inside %0d count %0d", $time,
                         o_inside_res, o_crossing_count);
                err_count++;
            end else begin
                want = fence_exp_q.pop_front();
                if (o_inside_res !== want.in_poly) begin
                    $display("%0t: inside_res expected %0d got %0d", $time,
                             want.in_poly, o_inside_res);
                    err_count++;
                end
                if (o_crossing_count !== want.count) begin
                    $display("%0t: crossing_count expected %0d got %0d", $time,
                             want.count, o_crossing_count);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request, result or write
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= IdleLimit) begin
            $display("%0t: no progress for %0d cycles", $time, IdleLimit);
            $display("point_in_polygon: mismatch");
            $finish;
        end
    end

    // Receiver stall pattern, with one long hold-off on request
    initial begin
        int mode, span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 200);
            repeat (span) begin
                @(posedge i_clk);
                if (hold_req) begin
                    i_out_stall <= 1'b1;
                    repeat (LongHold) @(posedge i_clk);
                    hold_req = 1'b0;
                end else begin
                    case (mode)
                        0: i_out_stall <= 1'b0;
                        1: i_out_stall <= $urandom_range(0, 1);
                        2: i_out_stall <= ($urandom_range(0, 7) != 0);
                        default: i_out_stall <= ($urandom_range(0, 2) == 0);
                    endcase
                end
            end
        end
    end

    // Stimulus
    initial begin
        t_dir_row   dir_rows [$];
        t_dir_row   row;
        t_fence_req rq;
        t_fence_res no_res;
        int first_counts [4];
        int phase_no, vc, scale, n_need, phase_len, missing, pick, k, s;
        bit hold_done;

        first_counts = '{16, 31, 0, 3};
        no_res = '{in_poly: 1'b0, count: '0};
        hold_done = 1'b0;

        // after reset the vertex count is zero: nothing can be crossed
        dir_rows.push_back(req_row(FUNC_QUERY, 0, 0, 0, 1'b1, 1'b0, 0));
        dir_rows.push_back(req_row(FUNC_QUERY, 15, 32'h7fff_ffff, 32'h8000_0000,
                                   1'b1, 1'b0, 0));
        // square around the origin
        dir_rows.push_back(req_row(FUNC_LOAD, 0, -100, -100));
        dir_rows.push_back(req_row(FUNC_LOAD, 1, 100, -100));
        dir_rows.push_back(req_row(FUNC_LOAD, 2, 100, 100));
        dir_rows.push_back(req_row(FUNC_LOAD, 3, -100, 100));
        // a single vertex gives a degenerate edge that never straddles
        dir_rows.push_back(cfg_row(1));
        dir_rows.push_back(req_row(FUNC_QUERY, 0, 0, 0, 1'b1, 1'b0, 0));
        dir_rows.push_back(cfg_row(4));
        dir_rows.push_back(req_row(FUNC_QUERY, 0, 0, 0));
        dir_rows.push_back(req_row(FUNC_QUERY, 0, 200, 0));
        dir_rows.push_back(req_row(FUNC_QUERY, 0, -200, 0));
        dir_rows.push_back(req_row(FUNC_QUERY, 0, 0, 100));      // on a horizontal edge
        dir_rows.push_back(req_row(FUNC_QUERY, 0, -100, -100));  // on a vertex
        dir_rows.push_back(req_row(FUNC_QUERY, 0, 100, 50));     // on a vertical edge
        // triangle spanning the full coordinate range
        dir_rows.push_back(req_row(FUNC_LOAD, 0, 32'h8000_0000, 32'h8000_0000));
        dir_rows.push_back(req_row(FUNC_LOAD, 1, 32'h7fff_ffff, 32'h8000_0000));
        dir_rows.push_back(req_row(FUNC_LOAD, 2, 0, 32'h7fff_ffff));
        dir_rows.push_back(cfg_row(3));
        dir_rows.push_back(req_row(FUNC_QUERY, 0, 0, 0));
        dir_rows.push_back(req_row(FUNC_QUERY, 0, 32'h7fff_ffff, 0));
        dir_rows.push_back(req_row(FUNC_QUERY, 0, 32'h8000_0000, 32'h8000_0001));
        dir_rows.push_back(req_row(FUNC_QUERY, 0, 0, 32'h7fff_ffff));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            if (row.kind == ROW_CFG) begin
                write_vcount(row.vcount);
            end else begin
                pace();
                send_req(row.req, row.typed, row.res);
            end
        end

        // random phases: rebuild the polygon, then mostly queries
        phase_no = 0;
        while (reqs_sent < TotalReqs) begin
            vc = (phase_no < 4) ? first_counts[phase_no] : $urandom_range(0, 31);
            write_vcount(vc[VcountBits-1:0]);
            poly_built = '0;
            scale = $urandom_range(0, 2);
            n_need = (vc > NumSlots) ? NumSlots : vc;
            phase_len = $urandom_range(40, 120);
            if (!hold_done && reqs_sent >= HoldAfter) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
                phase_len = 120;
            end
            for (k = 0; k < phase_len; k++) begin
                missing = -1;
                for (s = 0; s < n_need; s++)
                    if (!poly_built[s] && missing < 0) missing = s;
                rq.x = rand_coord(scale);
                rq.y = rand_coord(scale);
                rq.slot = $urandom_range(0, NumSlots - 1);
                if (missing >= 0) begin
                    rq.func = FUNC_LOAD;
                    rq.slot = missing[SlotBits-1:0];
                end else if ($urandom_range(0, 9) < 3) begin
                    rq.func = FUNC_LOAD;
                end else begin
                    rq.func = FUNC_QUERY;
                    // share a coordinate with a vertex to hit the tie cases
                    if (n_need > 0 && $urandom_range(0, 3) == 0) begin
                        pick = $urandom_range(0, n_need - 1);
                        if ($urandom_range(0, 1)) rq.x = fence_x[pick];
                        else rq.y = fence_y[pick];
                    end
                end
                pace();
                send_req(rq, 1'b0, no_res);
            end
            phase_no++;
        end

        i_in_valid <= 1'b0;
        while (fence_exp_q.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        if (err_count == 0)
            $display("point_in_polygon: match");
        else
            $display("point_in_polygon: mismatch");
        $finish;
    end

endmodule
